[design/sbit_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the breakpoint table.
`timescale 1ns / 1ps
package sbit_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic signed [31:0] SENT_LO = 32'sh8000_0000;
	localparam logic signed [31:0] SENT_HI = 32'sh7fff_ffff;

	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_DUP  = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic load;
		logic probe_rd;
		logic probe_upd;
		logic upper_rd;
		logic upper_upd;
		logic decide;
		logic shift_init;
		logic shift_rd;
		logic shift_wr;
		logic ins_wr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic search_more;
		logic is_eq;
		logic do_insert;
		logic need_shift;
		logic shift_last;
		logic out_free;
	} sts_t;

endpackage

[design/sbit_req_if.sv]
// Request channel: operation code and point value.
`timescale 1ns / 1ps
interface sbit_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] point;

	modport source (output valid, output func, output point, input ready);
	modport sink (input valid, input func, input point, output ready);
endinterface

[design/sbit_rsp_if.sv]
// Response channel: bounding breakpoints, status and entry count.
`timescale 1ns / 1ps
interface sbit_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] lower_bound;
	logic signed [31:0] upper_bound;
	logic [1:0]         status;
	logic [8:0]         entry_count;

	modport source (output valid, output lower_bound, output upper_bound, output status,
		output entry_count, input ready);
	modport sink (input valid, input lower_bound, input upper_bound, input status,
		input entry_count, output ready);
endinterface

[design/sbit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbit_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/sbit_ctrl.sv]
// Controller: sequences search probes, shift moves, insert write and result hand-off.
`timescale 1ns / 1ps
module sbit_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sbit_pkg::sts_t sts,
	output sbit_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_PROBE_RD  = 4'd1;
	localparam logic [3:0] S_PROBE_CMP = 4'd2;
	localparam logic [3:0] S_UPPER_RD  = 4'd3;
	localparam logic [3:0] S_UPPER_CMP = 4'd4;
	localparam logic [3:0] S_DECIDE    = 4'd5;
	localparam logic [3:0] S_SHIFT_RD  = 4'd6;
	localparam logic [3:0] S_SHIFT_WR  = 4'd7;
	localparam logic [3:0] S_INSERT_WR = 4'd8;
	localparam logic [3:0] S_FINISH    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.is_clear ? S_FINISH : S_PROBE_RD;
				end
			end
			S_PROBE_RD: begin
				if (sts.search_more) begin
					cmd.probe_rd = 1'b1;
					state_d      = S_PROBE_CMP;
				end else if (sts.is_eq) begin
					state_d = S_UPPER_RD;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_PROBE_CMP: begin
				cmd.probe_upd = 1'b1;
				state_d       = S_PROBE_RD;
			end
			S_UPPER_RD: begin
				cmd.upper_rd = 1'b1;
				state_d      = S_UPPER_CMP;
			end
			S_UPPER_CMP: begin
				cmd.upper_upd = 1'b1;
				state_d       = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (!sts.do_insert) begin
					state_d = S_FINISH;
				end else if (sts.need_shift) begin
					cmd.shift_init = 1'b1;
					state_d        = S_SHIFT_RD;
				end else begin
					state_d = S_INSERT_WR;
				end
			end
			S_SHIFT_RD: begin
				cmd.shift_rd = 1'b1;
				state_d      = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = sts.shift_last ? S_INSERT_WR : S_SHIFT_RD;
			end
			S_INSERT_WR: begin
				cmd.ins_wr = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				// hold until the output register can take the item
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/sbit_dp.sv]
// Datapath: search bounds, breakpoint RAM, shift pointer, entry count and output register.
`timescale 1ns / 1ps
module sbit_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sbit_pkg::cmd_t     cmd,
	output sbit_pkg::sts_t     sts,
	input  logic [1:0]         func,
	input  logic signed [31:0] point,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output logic signed [31:0] lower_bound,
	output logic signed [31:0] upper_bound,
	output logic [1:0]         status,
	output logic [8:0]         entry_count
);

	localparam int AW = sbit_pkg::ADDR_W;
	localparam int CW = sbit_pkg::CNT_W;

	logic [1:0]         func_q;
	logic signed [31:0] x_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic signed [31:0] lo_val_q;
	logic signed [31:0] hi_val_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      r_q;
	logic [1:0]         status_q;
	logic               out_valid_q;
	logic signed [31:0] out_lower_q;
	logic signed [31:0] out_upper_q;
	logic [1:0]         out_status_q;
	logic [8:0]         out_count_q;

	logic [AW:0]        mid_sum;
	logic [AW-1:0]      mid;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [31:0]        ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;
	logic signed [31:0] rd_val;
	logic               dup;
	logic               full;
	logic               upper_is_top;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[AW:1];
	assign rd_val  = signed'(ram_rdata);

	assign dup  = (lo_q == hi_q) || (x_q == sbit_pkg::SENT_LO) || (x_q == sbit_pkg::SENT_HI);
	assign full = (count_q >= sbit_pkg::CNT_FULL);
	// the top sentinel is never stored; it lives at index count - 1
	assign upper_is_top = ((CW'(lo_q) + CW'(1)) == (count_q - CW'(1)));

	assign sts.is_clear    = (func == sbit_pkg::FUNC_CLEAR);
	assign sts.search_more = ((hi_q - lo_q) > AW'(1));
	assign sts.is_eq       = (lo_q == hi_q);
	assign sts.do_insert   = (func_q == sbit_pkg::FUNC_INSERT) && !dup && !full;
	assign sts.need_shift  = ((CW'(hi_q) + CW'(1)) < count_q);
	assign sts.shift_last  = (r_q == hi_q);
	assign sts.out_free    = !out_valid_q || rsp_ready;

	always_comb begin
		ram_raddr = mid;
		if (cmd.upper_rd) begin
			ram_raddr = lo_q + AW'(1);
		end else if (cmd.shift_rd) begin
			ram_raddr = r_q;
		end
	end

	always_comb begin
		ram_we    = cmd.shift_wr || cmd.ins_wr;
		ram_waddr = hi_q;
		ram_wdata = x_q;
		if (cmd.shift_wr) begin
			ram_waddr = r_q + AW'(1);
			ram_wdata = ram_rdata;
		end
	end

	sbit_ram #(
		.DATA_W(32),
		.DEPTH (sbit_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= sbit_pkg::CNT_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && (func == sbit_pkg::FUNC_CLEAR)) begin
				count_q <= sbit_pkg::CNT_INIT;
			end else if (cmd.ins_wr) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			x_q      <= point;
			lo_q     <= '0;
			hi_q     <= AW'(count_q - CW'(1));
			lo_val_q <= sbit_pkg::SENT_LO;
			hi_val_q <= sbit_pkg::SENT_HI;
			status_q <= sbit_pkg::STAT_DONE;
		end
		if (cmd.probe_upd) begin
			if (rd_val <= x_q) begin
				lo_q     <= mid;
				lo_val_q <= rd_val;
			end
			if (rd_val >= x_q) begin
				hi_q     <= mid;
				hi_val_q <= rd_val;
			end
		end
		if (cmd.upper_upd) begin
			hi_val_q <= upper_is_top ? sbit_pkg::SENT_HI : rd_val;
		end
		if (cmd.decide) begin
			if (func_q != sbit_pkg::FUNC_INSERT) begin
				status_q <= sbit_pkg::STAT_DONE;
			end else if (dup) begin
				status_q <= sbit_pkg::STAT_DUP;
			end else if (full) begin
				status_q <= sbit_pkg::STAT_FULL;
			end else begin
				status_q <= sbit_pkg::STAT_DONE;
			end
		end
		if (cmd.shift_init) begin
			r_q <= AW'(count_q - CW'(2));
		end else if (cmd.shift_wr) begin
			r_q <= r_q - AW'(1);
		end
		if (cmd.finish) begin
			out_lower_q  <= lo_val_q;
			out_upper_q  <= hi_val_q;
			out_status_q <= status_q;
			out_count_q  <= 9'(count_q);
		end
	end

	assign rsp_valid   = out_valid_q;
	assign lower_bound = out_lower_q;
	assign upper_bound = out_upper_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= sbit_pkg::CNT_INIT) && (count_q <= sbit_pkg::CNT_FULL))
		else $error("entry count out of range");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.probe_rd || cmd.probe_upd) |-> (lo_q < hi_q))
		else $error("search bounds crossed");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not advance entry count");

	a_shift_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_wr |-> ((r_q >= hi_q) && !full))
		else $error("shift moved below insert slot or into a full table");
`endif

endmodule

[design/sorted_breakpoint_interval_table.sv]
// Sorted breakpoint table: insert, interval lookup and clear over one breakpoint RAM.
// From accept to result: a clear goes straight to the hand-off; a lookup runs the probes of
// the binary search (at most log2 of the entry count), each a RAM read then a compare, plus
// a read of the upper bound when the point equals an inner breakpoint. An insert then moves
// each entry above the slot up by one (a read, then a write) and writes the point. One item
// in flight; the next is accepted the cycle after the result loads into the output register.
// Reset: asynchronous; the table holds only the two sentinels, with no clearing pass.
`timescale 1ns / 1ps
module sorted_breakpoint_interval_table (
	input logic        clk,
	input logic        arst_n,
	sbit_req_if.sink   req,
	sbit_rsp_if.source rsp
);

	sbit_pkg::cmd_t cmd;
	sbit_pkg::sts_t sts;

	sbit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbit_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (req.func),
		.point      (req.point),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.lower_bound(rsp.lower_bound),
		.upper_bound(rsp.upper_bound),
		.status     (rsp.status),
		.entry_count(rsp.entry_count)
	);

endmodule
